// File: design/bc1_pkg.sv
// Shared types and helpers for the BC1 colour block decoder.
// Depends on nothing; every other design file refers to it by scoped name.
`default_nettype none

package bc1_pkg;

	localparam int unsigned NumPixels  = 16;
	localparam int unsigned PixIdxW    = 4;
	localparam int unsigned IndexBitsW = 32;
	localparam logic [7:0]  AlphaOpaque = 8'hFF;
	localparam logic [7:0]  AlphaClear  = 8'h00;
	localparam logic [1:0]  SelTransparent = 2'h3;
	localparam logic [PixIdxW-1:0] LastPixIdx = 4'd15;

	// Reciprocal of three in 11 fractional bits; exact floor for x below 2048
	localparam logic [10:0] Recip3 = 11'd683;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// One classified block as it waits between front and back
	typedef struct packed {
		rgb_t [3:0]             pal;
		logic                   three_colour;
		logic [IndexBitsW-1:0]  index_bits;
	} blk_t;

	// One decoded pixel
	typedef struct packed {
		logic [PixIdxW-1:0] idx;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [7:0]         a;
		logic               last;
	} pix_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	function automatic rgb_t unpack565(input logic [15:0] c);
		rgb_t o;
		o.r = widen5(c[15:11]);
		o.g = widen6(c[10:5]);
		o.b = widen5(c[4:0]);
		return o;
	endfunction

	// (2a + b + 1) / 3 through the reciprocal
	function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
		logic [9:0]  s;
		logic [20:0] p;
		s = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
		p = {11'd0, s} * {10'd0, Recip3};
		return p[18:11];
	endfunction

	function automatic logic [7:0] mix_half(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

endpackage

`default_nettype wire

// File: design/bc1_front.sv
// Front end: takes a BC1 block, expands endpoints and builds the palette.
// Uses bc1_pkg; feeds bc1_queue through one staging register.
`default_nettype none

module bc1_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [15:0]           first_color,
	input  wire logic [15:0]           second_color,
	input  wire logic [31:0]           index_bits,
	input  wire logic                  q_full,
	output logic                       q_push,
	output bc1_pkg::blk_t              q_data
);

	bc1_pkg::rgb_t c0;
	bc1_pkg::rgb_t c1;
	bc1_pkg::blk_t blk;
	bc1_pkg::blk_t blk_s1;
	logic          valid_s1;
	logic          load;

	always_comb begin
		c0 = bc1_pkg::unpack565(first_color);
		c1 = bc1_pkg::unpack565(second_color);
		blk.pal[0]       = c0;
		blk.pal[1]       = c1;
		blk.index_bits   = index_bits;
		blk.three_colour = (first_color <= second_color);
		if (blk.three_colour) begin
			blk.pal[2].r = bc1_pkg::mix_half(c0.r, c1.r);
			blk.pal[2].g = bc1_pkg::mix_half(c0.g, c1.g);
			blk.pal[2].b = bc1_pkg::mix_half(c0.b, c1.b);
			blk.pal[3]   = '0;
		end else begin
			blk.pal[2].r = bc1_pkg::mix_third(c0.r, c1.r);
			blk.pal[2].g = bc1_pkg::mix_third(c0.g, c1.g);
			blk.pal[2].b = bc1_pkg::mix_third(c0.b, c1.b);
			blk.pal[3].r = bc1_pkg::mix_third(c1.r, c0.r);
			blk.pal[3].g = bc1_pkg::mix_third(c1.g, c0.g);
			blk.pal[3].b = bc1_pkg::mix_third(c1.b, c0.b);
		end
	end

	// Stage frees up when empty or when its block moves into the queue
	assign full   = valid_s1 & q_full;
	assign load   = push & ~full;
	assign q_push = valid_s1 & ~q_full;
	assign q_data = blk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blk_s1 <= blk;
		end
	end

endmodule

`default_nettype wire

// File: design/bc1_queue.sv
// Short queue of classified blocks between front and back end.
// Uses bc1_pkg for the block type; depth comes from the top level.
`default_nettype none

module bc1_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bc1_pkg::blk_t  wdata,
	output logic                full,
	input  wire logic           pop,
	output bc1_pkg::blk_t       rdata,
	output logic                empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

	bc1_pkg::blk_t slot_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LastSlot) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LastSlot) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// File: design/bc1_back.sv
// Back end: walks the sixteen pixels of the oldest queued block.
// Uses bc1_pkg; holds each pixel in an output register until popped.
`default_nettype none

module bc1_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bc1_pkg::blk_t  q_data,
	input  wire logic           q_empty,
	output logic                q_pop,
	output bc1_pkg::pix_t       pix,
	output logic                empty,
	input  wire logic           pop
);

	logic [bc1_pkg::PixIdxW-1:0] cnt_q;
	logic                        out_valid_q;
	bc1_pkg::pix_t               pix_q;
	bc1_pkg::pix_t               nxt;
	logic                        advance;
	logic [1:0]                  sel;

	// Take a new pixel when the output register is free or being drained
	assign advance = ~q_empty & (~out_valid_q | pop);
	assign q_pop   = advance & (cnt_q == bc1_pkg::LastPixIdx);
	assign empty   = ~out_valid_q;
	assign pix     = pix_q;

	always_comb begin
		sel      = q_data.index_bits[{cnt_q, 1'b0} +: 2];
		nxt.idx  = cnt_q;
		nxt.r    = q_data.pal[sel].r;
		nxt.g    = q_data.pal[sel].g;
		nxt.b    = q_data.pal[sel].b;
		nxt.a    = (q_data.three_colour && sel == bc1_pkg::SelTransparent) ?
		           bc1_pkg::AlphaClear : bc1_pkg::AlphaOpaque;
		nxt.last = (cnt_q == bc1_pkg::LastPixIdx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q <= nxt;
		end
	end

`ifndef SYNTHESIS
	a_last_is_fifteen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pix_q.last |-> pix_q.idx == bc1_pkg::LastPixIdx)
		else $error("last pixel flag away from pixel fifteen");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty && cnt_q == bc1_pkg::LastPixIdx)
		else $error("block released before its last pixel");

	a_pixel_order: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> pix_q.idx == $past(cnt_q) && cnt_q == $past(cnt_q) + 4'd1)
		else $error("pixel counter out of step with output");
`endif

endmodule

`default_nettype wire

// File: design/bc1_color_block_decode.sv
// BC1 (DXT1) colour block decoder, top level: queue ports, register port.
// Instantiates bc1_front, bc1_queue and bc1_back; uses bc1_pkg.
// Each accepted beat is one 64-bit block (two RGB565 endpoints and sixteen
// 2-bit indices); it yields sixteen result beats in raster order, pixel_index
// 0 to 15, last_pixel set on the sixteenth. Endpoints widen to 8 bits per
// channel by bit replication. With first_color above second_color the palette
// is four opaque colours with the two thirds mixes; otherwise it is the two
// endpoints, their floor average and transparent black (alpha 0). The back
// end's pixel counter sets the rate: one result beat per cycle while pop is
// held high and the queue is not empty. On its way to the result ports a block
// passes the staging register, a queue slot and the output register, in that
// order. Up to one staged block and QUEUE_DEPTH queued blocks, the one in
// decode among them, are held, so a few more blocks are still taken while
// results stall. Register with_alpha (byte address 0, reset 1) is copied to
// alpha_write on every pixel; alpha itself always carries the decoded value.
// Write it only while the block is idle.
`default_nettype none

module bc1_color_block_decode #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Block input
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] first_color,
	input  wire logic [15:0] second_color,
	input  wire logic [31:0] index_bits,
	// Pixel results
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             alpha_write,
	output logic             last_pixel,
	// Register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	bc1_pkg::blk_t front_data;
	bc1_pkg::blk_t back_data;
	bc1_pkg::pix_t pix;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	logic          with_alpha_q;
	logic          reg_hit;

	// Register map: a single bit at word 0; other words read as zero, writes dropped
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'b0);
	assign prdata  = reg_hit ? {31'd0, with_alpha_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			with_alpha_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			with_alpha_q <= pwdata[0];
		end
	end

	// Front: expand endpoints, classify the mode, build the palette
	bc1_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.first_color  (first_color),
		.second_color (second_color),
		.index_bits   (index_bits),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (front_data)
	);

	// Decouple: hold finished palettes while the back end streams pixels
	bc1_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_data),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (back_data),
		.empty  (q_empty)
	);

	// Back: advance one pixel per beat through the head block
	bc1_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (back_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pix     (pix),
		.empty   (empty),
		.pop     (pop)
	);

	assign pixel_index = pix.idx;
	assign red         = pix.r;
	assign green       = pix.g;
	assign blue        = pix.b;
	assign alpha       = pix.a;
	assign last_pixel  = pix.last;
	assign alpha_write = with_alpha_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for bc1_color_block_decode: it drives BC1 colour blocks in and checks each pixel beat.
// Expected pixels come from a behavioural palette decoder held here. Needs the RTL and bc1_pkg.

module tb;

	// Register map: with_alpha at byte 0; byte 4 decodes to nothing
	localparam logic [2:0] AddrWithAlpha = 3'd0;
	localparam logic [2:0] AddrUnmapped  = 3'd4;
	localparam logic [1:0] SelTransparent = bc1_pkg::SelTransparent;

	typedef struct packed {
		logic [3:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       aw;
		logic       last;
	} pixel_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [15:0] first_color = 16'h0000;
	logic [15:0] second_color = 16'h0000;
	logic [31:0] index_bits = 32'h0000_0000;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  pixel_index;
	logic [7:0]  red, green, blue, alpha;
	logic        alpha_write;
	logic        last_pixel;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'h0000_0000;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the with_alpha register and the pixels still owed by the block
	logic        alpha_enable_shadow = 1'b1;
	pixel_beat_t pending_pixels[$];
	int unsigned mismatch_count = 0;

	// Idling controls shared by the sender and the pop process
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned hold_cycles = 0;

	bc1_color_block_decode dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.first_color  (first_color),
		.second_color (second_color),
		.index_bits   (index_bits),
		.empty        (empty),
		.pop          (pop),
		.pixel_index  (pixel_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.alpha_write  (alpha_write),
		.last_pixel   (last_pixel),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	// Widen one 565 channel to eight bits by repeating its top bits into the gap
	function automatic int unsigned expand_channel(input int unsigned v, input int unsigned bits);
		return (v << (8 - bits)) | (v >> (2 * bits - 8));
	endfunction

	// Build the four-entry palette and queue the sixteen pixels in raster order.
	// Four-colour mode only when the first endpoint is strictly greater;
	// equal endpoints fall into three-colour mode with transparent black at index 3.
	function automatic void decode_block(input logic [15:0] c0, input logic [15:0] c1,
			input logic [31:0] sel_bits);
		int unsigned pal_rgb[4][3];
		logic [7:0]  pal_a[4];
		pixel_beat_t px;
		logic [1:0]  sel;
		pal_rgb[0][0] = expand_channel(c0[15:11], 5);
		pal_rgb[0][1] = expand_channel(c0[10:5], 6);
		pal_rgb[0][2] = expand_channel(c0[4:0], 5);
		pal_rgb[1][0] = expand_channel(c1[15:11], 5);
		pal_rgb[1][1] = expand_channel(c1[10:5], 6);
		pal_rgb[1][2] = expand_channel(c1[4:0], 5);
		pal_a[0] = 8'hFF;
		pal_a[1] = 8'hFF;
		pal_a[2] = 8'hFF;
		for (int ch = 0; ch < 3; ch++) begin
			if (c0 > c1) begin
				pal_rgb[2][ch] = (2 * pal_rgb[0][ch] + pal_rgb[1][ch] + 1) / 3;
				pal_rgb[3][ch] = (pal_rgb[0][ch] + 2 * pal_rgb[1][ch] + 1) / 3;
			end else begin
				pal_rgb[2][ch] = (pal_rgb[0][ch] + pal_rgb[1][ch]) / 2;
				pal_rgb[3][ch] = 0;
			end
		end
		pal_a[SelTransparent] = (c0 > c1) ? 8'hFF : 8'h00;
		for (int k = 0; k < 16; k++) begin
			sel     = sel_bits[2*k +: 2];
			px.idx  = k[3:0];
			px.r    = pal_rgb[sel][0][7:0];
			px.g    = pal_rgb[sel][1][7:0];
			px.b    = pal_rgb[sel][2][7:0];
			px.a    = pal_a[sel];
			px.aw   = alpha_enable_shadow;
			px.last = (k == 15);
			pending_pixels.push_back(px);
		end
	endfunction

	// Offer one block; leave push high on return so back-to-back beats stay gapless
	task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
			input logic [31:0] sel_bits);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		push         <= 1'b1;
		first_color  <= c0;
		second_color <= c1;
		index_bits   <= sel_bits;
		do @(posedge clk); while (full);
		decode_block(c0, c1, sel_bits);
	endtask

	task automatic stop_push();
		push <= 1'b0;
	endtask

	// Wait until every owed pixel has been seen, then let the pipeline settle
	task automatic drain();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == AddrWithAlpha) alpha_enable_shadow = data[0];
	endtask

	// Read with_alpha back; sample prdata in the access cycle
	task automatic check_alpha_reg();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= AddrWithAlpha;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== alpha_enable_shadow) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("with_alpha read: expected %0b, got %0b", alpha_enable_shadow, prdata[0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random endpoints with a bias towards the mode boundary and the extremes
	task automatic send_random_block();
		logic [15:0] c0, c1;
		c0 = 16'($urandom_range(0, 65535));
		c1 = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 7))
			0: c1 = c0;
			1: c1 = c0 - 16'd1;
			2: c0 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			3: c1 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: ;
		endcase
		send_block(c0, c1, $urandom());
	endtask

	// Pop side: random stalls while idling is on, and a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare every accepted pixel beat with the oldest owed pixel
	always @(posedge clk) begin : check_beat
		pixel_beat_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{pixel_index, red, green, blue, alpha, alpha_write, last_pixel};
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected pixel beat: idx %0d rgba %h %h %h %h",
						pixel_index, red, green, blue, alpha);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("pixel mismatch: expected idx %0d rgba %h%h%h%h aw %0b last %0b, got idx %0d rgba %h%h%h%h aw %0b last %0b",
							want.idx, want.r, want.g, want.b, want.a, want.aw, want.last,
							got.idx, got.r, got.g, got.b, got.a, got.aw, got.last);
				end
			end
		end
	end

	task automatic test_register_reset();
		check_alpha_reg();
	endtask

	// Endpoint extremes, both palette modes, every index value
	task automatic test_endpoint_extremes();
		send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
		send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
		send_block(16'h1234, 16'h1234, 32'hFFFF_FFFF);
		send_block(16'h0000, 16'h0000, 32'h0000_0000);
		send_block(16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA);
		send_block(16'hF800, 16'h07E0, 32'h5555_5555);
		send_block(16'h001F, 16'hF800, 32'h1B1B_1B1B);
		send_block(16'h0001, 16'h0000, 32'hFFFF_0000);
		send_block(16'h8000, 16'h7FFF, 32'h0123_4567);
		send_block(16'h7FFF, 16'h8000, 32'hFEDC_BA98);
		stop_push();
		drain();
	endtask

	// Writes off: alpha still carries the decoded value, alpha_write drops
	task automatic test_alpha_disabled();
		write_reg(AddrWithAlpha, 32'hFFFF_FFFE);
		check_alpha_reg();
		send_block(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_block(16'hABCD, 16'hABCD, 32'hC3C3_3C3C);
		send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
		stop_push();
		drain();
	endtask

	// A write to an unmapped slot must leave with_alpha alone
	task automatic test_unmapped_write();
		write_reg(AddrUnmapped, 32'h0000_0001);
		check_alpha_reg();
		send_block(16'h2000, 16'h4000, 32'hD8D8_D8D8);
		stop_push();
		drain();
		write_reg(AddrWithAlpha, 32'h0000_0001);
		check_alpha_reg();
		write_reg(AddrUnmapped, 32'h0000_0000);
		send_block(16'h4000, 16'h2000, 32'h8D8D_8D8D);
		stop_push();
		drain();
	endtask

	task automatic test_random_blocks(input int unsigned count);
		repeat (count) send_random_block();
		stop_push();
		drain();
	endtask

	// Hold pop low long enough for the block to fill and drop its input
	task automatic test_output_stall();
		hold_cycles = 300;
		hold_req    = 1'b1;
		repeat (10) send_random_block();
		stop_push();
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_endpoint_extremes();
		test_alpha_disabled();
		test_unmapped_write();

		test_random_blocks(50);
		test_output_stall();
		write_reg(AddrWithAlpha, 32'h8000_0000);
		test_random_blocks(40);
		write_reg(AddrWithAlpha, 32'h7FFF_FFFF);
		check_alpha_reg();

		// Final stretch runs with no idling on either side
		idle_on = 1'b0;
		test_random_blocks(50);

		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("bc1_color_block_decode test passed");
		else
			$display("bc1_color_block_decode test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("bc1_color_block_decode test failed");
		$finish;
	end

endmodule

// File: filelist.f
design/bc1_pkg.sv
design/bc1_front.sv
design/bc1_queue.sv
design/bc1_back.sv
design/bc1_color_block_decode.sv
verif/tb.sv
